FILE: hw/rtl/lpt_pkg.sv
// Shared constants and types for the LRU page translator.
`timescale 1ns / 1ps

package lpt_pkg;

    localparam int ADDR_W      = 12;
    localparam int PHYS_W      = 10;
    localparam int FAULT_W     = 32;
    localparam int OFFSET_BITS = 7;
    localparam int PAGE_COUNT  = 32;
    localparam int FRAME_COUNT = 8;

    localparam int PAGE_W  = ADDR_W - OFFSET_BITS;
    localparam int FRAME_W = $clog2(FRAME_COUNT);

    // Stream widths, rounded up to whole bytes.
    localparam int S_DATA_W = ((ADDR_W + 7) / 8) * 8;
    localparam int M_RAW_W  = PHYS_W + 1 + FAULT_W;
    localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8;

    // Field positions in m_tdata.
    localparam int M_PHYS_LSB  = 0;
    localparam int M_FAULT_BIT = PHYS_W;
    localparam int M_TOTAL_LSB = PHYS_W + 1;

    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    // Request from the translation stage to the frame table.
    typedef struct packed {
        logic               en;
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic [PAGE_W-1:0]  page;
    } frame_req_t;

    // Frame chosen for the access and the page that loses its frame, if any.
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               evict;
        logic [PAGE_W-1:0]  evict_page;
    } frame_rsp_t;

endpackage

FILE: hw/rtl/lpt_frame_table.sv
// Frame table: busy flags, owners and recency ranks, with free search and LRU victim choice.
`timescale 1ns / 1ps

module lpt_frame_table (
    input  logic               aclk,
    input  logic               aresetn,
    input  lpt_pkg::frame_req_t req_i,
    output lpt_pkg::frame_rsp_t rsp_o
);
    import lpt_pkg::*;

    logic [FRAME_COUNT-1:0] busy_reg;
    logic [FRAME_COUNT-1:0] busy_next;
    logic [FRAME_W-1:0]     rank_reg  [FRAME_COUNT];
    logic [FRAME_W-1:0]     rank_next [FRAME_COUNT];
    logic [PAGE_W-1:0]      owner_reg [FRAME_COUNT];

    logic               found;
    logic [FRAME_W-1:0] free_frame;
    logic [FRAME_W-1:0] victim;
    logic [FRAME_W-1:0] best;
    logic [FRAME_W-1:0] sel;
    logic [FRAME_W-1:0] sel_rank;

    // Lowest free user frame, and the user frame with the highest rank
    // (ties go to the higher index).
    always_comb begin
        found      = 1'b0;
        free_frame = '0;
        for (int i = FRAME_COUNT - 1; i >= 1; i--) begin
            if (!busy_reg[i]) begin
                found      = 1'b1;
                free_frame = FRAME_W'(i);
            end
        end
        best   = '0;
        victim = FRAME_W'(1);
        for (int i = 1; i < FRAME_COUNT; i++) begin
            if (rank_reg[i] >= best) begin
                best   = rank_reg[i];
                victim = FRAME_W'(i);
            end
        end
    end

    assign sel      = req_i.hit ? req_i.frame : (found ? free_frame : victim);
    assign sel_rank = rank_reg[sel];

    assign rsp_o.frame      = sel;
    assign rsp_o.evict      = !req_i.hit && !found;
    assign rsp_o.evict_page = owner_reg[victim];

    // On a hit only frames more recent than the touched one age; on a miss
    // every busy user frame ages. The selected frame becomes rank zero.
    always_comb begin
        busy_next = busy_reg;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            rank_next[i] = rank_reg[i];
        end
        if (req_i.en) begin
            if (!req_i.hit) begin
                busy_next[sel] = 1'b1;
            end
            for (int i = 1; i < FRAME_COUNT; i++) begin
                if (FRAME_W'(i) == sel) begin
                    rank_next[i] = '0;
                end else if (busy_reg[i] && (!req_i.hit || rank_reg[i] < sel_rank)) begin
                    rank_next[i] = rank_reg[i] + FRAME_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= FRAME_COUNT'(1);
            for (int i = 0; i < FRAME_COUNT; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            busy_reg <= busy_next;
            for (int i = 0; i < FRAME_COUNT; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_i.en && !req_i.hit) begin
            owner_reg[sel] <= req_i.page;
        end
    end

endmodule

FILE: hw/rtl/lru_page_translator.sv
// Top level of the LRU page translator: page table memory, fault counter and stream ports.
`timescale 1ns / 1ps

// Translates each virtual address into a physical address. The upper address
// bits select a page; if the page is resident its frame is returned with the
// original offset and the frame becomes the most recently used one. Otherwise
// a fault is counted (saturating at all ones), and the page gets the lowest
// free frame or, when every frame is taken, the least recently used frame,
// whose previous page is dropped. Frame 0 is reserved and never handed out.
// Each input transfer yields exactly one output transfer. An item first reads
// the page frame memory (synchronous read), then goes through the frame table
// update and the write back. A single item is in flight at a time, so a new
// item is taken only after the last one has finished its update. The result
// sits in an output register; a new item is taken while that result still
// waits, and the block stalls only when a second result would have nowhere to
// go. No clearing pass is needed after reset.
module lru_page_translator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [11:0] virtual_address, upper bits zero
    input  logic [lpt_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [9:0] physical_address, [10] page_fault, [42:11] fault_total, upper bits zero
    output logic [lpt_pkg::M_DATA_W-1:0] m_tdata
);
    import lpt_pkg::*;

    // Page frame store, written only on a fault, read on every accepted transfer.
    logic [FRAME_W-1:0] frame_mem [PAGE_COUNT];
    logic [FRAME_W-1:0] frame_rd_reg;

    // Residency flags, cleared at reset.
    logic [PAGE_COUNT-1:0] present_reg;
    logic [PAGE_COUNT-1:0] present_next;

    logic                   busy_reg;
    logic [PAGE_W-1:0]      page_reg;
    logic [OFFSET_BITS-1:0] offset_reg;

    logic [FAULT_W-1:0] count_reg;
    logic [FAULT_W-1:0] count_next;

    logic               out_valid_reg;
    logic [PHYS_W-1:0]  out_phys_reg;
    logic               out_fault_reg;
    logic [FAULT_W-1:0] out_total_reg;

    logic       accept;
    logic       finish;
    logic       hit;
    frame_req_t ft_req;
    frame_rsp_t ft_rsp;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;
    // The update step completes once the output register is free or draining.
    assign finish   = busy_reg && (!out_valid_reg || m_tready);
    assign hit      = present_reg[page_reg];

    assign ft_req.en    = finish;
    assign ft_req.hit   = hit;
    assign ft_req.frame = frame_rd_reg;
    assign ft_req.page  = page_reg;

    lpt_frame_table u_frame_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_i   (ft_req),
        .rsp_o   (ft_rsp)
    );

    always_ff @(posedge aclk) begin
        if (accept) begin
            frame_rd_reg <= frame_mem[s_tdata[ADDR_W-1:OFFSET_BITS]];
        end
        if (finish && !hit) begin
            frame_mem[page_reg] <= ft_rsp.frame;
        end
    end

    always_comb begin
        present_next = present_reg;
        count_next   = count_reg;
        if (finish && !hit) begin
            if (ft_rsp.evict) begin
                present_next[ft_rsp.evict_page] = 1'b0;
            end
            present_next[page_reg] = 1'b1;
            if (count_reg != FAULT_MAX) begin
                count_next = count_reg + FAULT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg   <= '0;
            count_reg     <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            present_reg <= present_next;
            count_reg   <= count_next;
            if (accept) begin
                busy_reg <= 1'b1;
            end else if (finish) begin
                busy_reg <= 1'b0;
            end
            if (finish) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            page_reg   <= s_tdata[ADDR_W-1:OFFSET_BITS];
            offset_reg <= s_tdata[OFFSET_BITS-1:0];
        end
        if (finish) begin
            out_phys_reg  <= {ft_rsp.frame, offset_reg};
            out_fault_reg <= !hit;
            out_total_reg <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_DATA_W - M_RAW_W)'(0), out_total_reg, out_fault_reg, out_phys_reg};

endmodule

FILE: hw/rtl/lpt_checker.sv
// Port-level checks for the LRU page translator, bound to the top level.
`timescale 1ns / 1ps

module lpt_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [lpt_pkg::M_DATA_W-1:0] m_tdata
);
    import lpt_pkg::*;

    logic               seen_reg;
    logic [FAULT_W-1:0] last_total_reg;
    logic               m_xfer;
    logic               m_fault;
    logic [FAULT_W-1:0] m_total;
    logic [FRAME_W-1:0] m_frame;

    assign m_xfer  = m_tvalid && m_tready;
    assign m_fault = m_tdata[M_FAULT_BIT];
    assign m_total = m_tdata[M_TOTAL_LSB +: FAULT_W];
    assign m_frame = m_tdata[M_PHYS_LSB + OFFSET_BITS +: FRAME_W];

    // Fault total of the last delivered result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg       <= 1'b0;
            last_total_reg <= '0;
        end else if (m_xfer) begin
            seen_reg       <= 1'b1;
            last_total_reg <= m_total;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    a_no_reserved_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_frame != '0)
        else $error("reserved frame handed out");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_xfer && seen_reg |->
            (!m_fault && m_total == last_total_reg) ||
            (m_fault && (m_total == last_total_reg + FAULT_W'(1) ||
                         (m_total == FAULT_MAX && last_total_reg == FAULT_MAX))))
        else $error("fault total does not follow the fault flags");

endmodule

bind lru_page_translator lpt_checker u_lpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
